// ----- rtl/base64_stream_codec_top_assert.svh -----
// Assertion macros for the codec RTL, included by the result holding register.
`ifndef BASE64_STREAM_CODEC_TOP_ASSERT_SVH
`define BASE64_STREAM_CODEC_TOP_ASSERT_SVH

// Checked only out of reset.
`define B64SC_ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define B64SC_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/b64sc_pkg.sv -----
// Types, constants and alphabet functions for the Base64 codec.
`default_nettype none
package b64sc_pkg;

	localparam int unsigned MaxRes = 4;
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	typedef struct packed {
		logic [7:0] data;
		logic       dvalid;
		logic       last;
	} res_t;

	typedef struct packed {
		res_t [MaxRes-1:0] item;
		logic [2:0]        cnt;
	} bundle_t;

	// 6-bit value to alphabet character
	function automatic logic [7:0] enc_char(input logic [5:0] v);
		logic [7:0] c;
		if (v < 6'd26)
			c = 8'h41 + {2'b00, v};
		else if (v < 6'd52)
			c = 8'h61 + {2'b00, v} - 8'd26;
		else if (v < 6'd62)
			c = 8'h30 + {2'b00, v} - 8'd52;
		else if (v == 6'd62)
			c = 8'h2B;
		else
			c = 8'h2F;
		return c;
	endfunction

	// character to 6-bit value; anything outside the alphabet maps to 63
	function automatic logic [5:0] sextet_of(input logic [7:0] c);
		logic [5:0] v;
		if (c >= 8'h41 && c <= 8'h5A)
			v = 6'(c - 8'h41);
		else if (c >= 8'h61 && c <= 8'h7A)
			v = 6'(c - 8'h61 + 8'd26);
		else if (c >= 8'h30 && c <= 8'h39)
			v = 6'(c - 8'h30 + 8'd52);
		else if (c == 8'h2B)
			v = 6'd62;
		else
			v = 6'd63;
		return v;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/b64sc_step.sv -----
// Message state and the expansion of one registered item into its result beats.
`default_nettype none
module b64sc_step (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              decode_mode,
	input  wire logic              clear,
	input  wire logic              take,
	input  wire logic [7:0]        sym,
	input  wire logic              fin,
	output b64sc_pkg::bundle_t     bundle
);
	import b64sc_pkg::*;

	logic [13:0] acc_q;
	logic [3:0]  bc_q;
	logic [1:0]  cm_q;
	logic        pad_q;

	logic [13:0] acc_n;
	logic [3:0]  bc_n;
	logic [1:0]  cm_n;
	logic        pad_n;

	// encode path
	logic [13:0] acc_e;
	logic [3:0]  bc_e, bc_r;
	logic [5:0]  c0, c1, ctail;
	logic        two, tail;
	logic [2:0]  nchr, total, cnt;
	logic [1:0]  cm1, cm2, pads;

	// decode path
	logic [5:0]  sx;
	logic [13:0] acc_d;
	logic [3:0]  bc_d;
	logic        got, byte_ok;
	logic [7:0]  dbyte;

	always_comb begin
		acc_e = {acc_q[5:0], sym};
		bc_e  = bc_q + 4'd8;
		two   = (bc_e >= 4'd12);
		c0    = 6'(acc_e >> (bc_e - 4'd6));
		c1    = 6'(acc_e >> (bc_e - 4'd12));
		bc_r  = two ? (bc_e - 4'd12) : (bc_e - 4'd6);
		nchr  = two ? 3'd2 : 3'd1;
		tail  = fin && (bc_r != 4'd0);
		ctail = 6'({2'b00, acc_e[5:0]} << (4'd6 - bc_r));
		cm1   = cm_q + nchr[1:0];
		cm2   = cm1 + {1'b0, tail};
		pads  = fin ? (2'd0 - cm2) : 2'd0;
		total = nchr + {2'b00, tail} + {1'b0, pads};

		sx      = sextet_of(sym);
		acc_d   = {acc_q[7:0], sx};
		bc_d    = bc_q + 4'd6;
		got     = !pad_q && (sym != PAD_CHAR);
		byte_ok = got && (bc_d >= 4'd8);
		dbyte   = 8'(acc_d >> (bc_d - 4'd8));

		bundle = '0;
		if (!decode_mode) begin
			cnt = (total > 3'(MaxRes)) ? 3'(MaxRes) : total;
			for (int k = 0; k < MaxRes; k++) begin
				if (3'(k) < nchr)
					bundle.item[k].data = enc_char((k == 0) ? c0 : c1);
				else if (3'(k) < nchr + {2'b00, tail})
					bundle.item[k].data = enc_char(ctail);
				else
					bundle.item[k].data = PAD_CHAR;
				bundle.item[k].dvalid = 1'b1;
				bundle.item[k].last   = fin && (3'(k) == cnt - 3'd1);
			end
			acc_n = acc_e;
			bc_n  = bc_r;
			cm_n  = cm2;
			pad_n = pad_q;
		end else begin
			cnt = (byte_ok || fin) ? 3'd1 : 3'd0;
			bundle.item[0].data   = byte_ok ? dbyte : 8'd0;
			bundle.item[0].dvalid = byte_ok;
			bundle.item[0].last   = fin;
			acc_n = got ? acc_d : acc_q;
			bc_n  = byte_ok ? (bc_d - 4'd8) : (got ? bc_d : bc_q);
			cm_n  = cm_q;
			pad_n = pad_q || (sym == PAD_CHAR);
		end
		bundle.cnt = cnt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			bc_q  <= '0;
			cm_q  <= '0;
			pad_q <= 1'b0;
		end else if (clear || (take && fin)) begin
			acc_q <= '0;
			bc_q  <= '0;
			cm_q  <= '0;
			pad_q <= 1'b0;
		end else if (take) begin
			acc_q <= acc_n;
			bc_q  <= bc_n;
			cm_q  <= cm_n;
			pad_q <= pad_n;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/b64sc_drain.sv -----
// Holding register: takes an item's beats at once, sends one per cycle while m_ready.
`default_nettype none
module b64sc_drain (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire b64sc_pkg::bundle_t bundle,
	output logic                   free,
	output logic                   m_valid,
	input  wire logic              m_ready,
	output b64sc_pkg::res_t        m_res
);
	import b64sc_pkg::*;

	res_t [MaxRes-1:0] buf_q;
	logic [2:0]        rem_q;
	logic [1:0]        idx_q;
	logic              fire;

	assign m_valid = (rem_q != 3'd0);
	assign fire    = m_valid && m_ready;
	assign free    = (rem_q == 3'd0) || ((rem_q == 3'd1) && m_ready);
	assign m_res   = buf_q[idx_q];

	always_ff @(posedge clk) begin
		if (load)
			buf_q <= bundle.item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			rem_q <= bundle.cnt;
			idx_q <= '0;
		end else if (fire) begin
			rem_q <= rem_q - 3'd1;
			idx_q <= idx_q + 2'd1;
		end
	end

`include "base64_stream_codec_top_assert.svh"

	`B64SC_ASSERT_ALWAYS(a_rem_range, rem_q <= 3'(MaxRes), "beat count beyond holding depth")
	`B64SC_ASSERT_CLK(a_load_free, load |-> free, "item loaded over beats still pending")
	`B64SC_ASSERT_CLK(a_last_final, (m_valid && m_res.last) |-> (rem_q == 3'd1), "tlast before final beat")

endmodule
`default_nettype wire

// ----- rtl/base64_stream_codec_top.sv -----
// Base64 codec top level: mode register, input register, message logic and result holding.
//
// Streaming Base64 codec. decode_mode (written on the cfg channel; the user must write it only
// while idle, which the block itself does not enforce; any write also restarts the message)
// selects encoding of raw bytes into alphabet characters or decoding of characters back into
// bytes. tlast on the input marks the end of a message: the encoder then flushes the zero-filled
// final character and pads with '=', the decoder closes with tlast on its last byte or on a bare
// end beat (tuser low). An accepted item is registered, then expanded combinationally into up to
// four result beats, which leave one per cycle while m_axis_tready is high from a holding
// register that is refilled on its final beat, so an item with beats waits until it is free.
// An item yields at most one beat when decoding (a byte once enough characters are in, or the
// bare end beat), one or two per byte mid-message when encoding, up to four at message end.
// Each input beat passes the input register and then the holding register before any result.
`default_nettype none
module base64_stream_codec_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	// configuration: decode_mode
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       cfg_data,
	// input stream
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] symbol_in
	input  wire logic       s_axis_tlast,   // final_item
	// result stream
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] data_out
	output logic            m_axis_tuser,   // data_valid
	output logic            m_axis_tlast    // last_out
);
	import b64sc_pkg::*;

	logic       mode_q;
	logic       valid_s1;
	logic [7:0] sym_s1;
	logic       fin_s1;

	logic       cfg_fire, s_fire, take, load, free;
	bundle_t    bundle;
	res_t       m_res;

	assign cfg_ready     = 1'b1;
	assign cfg_fire      = cfg_valid && cfg_ready;
	// an item with no beats can retire even while the holding register is busy
	assign take          = valid_s1 && ((bundle.cnt == 3'd0) || free);
	assign load          = take && (bundle.cnt != 3'd0);
	assign s_axis_tready = !valid_s1 || take;
	assign s_fire        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			mode_q <= 1'b0;
		else if (cfg_fire)
			mode_q <= cfg_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_fire)
			valid_s1 <= 1'b1;
		else if (take)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			sym_s1 <= s_axis_tdata;
			fin_s1 <= s_axis_tlast;
		end
	end

	b64sc_step u_step (
		.clk         (clk),
		.arst_n      (arst_n),
		.decode_mode (mode_q),
		.clear       (cfg_fire),
		.take        (take),
		.sym         (sym_s1),
		.fin         (fin_s1),
		.bundle      (bundle)
	);

	b64sc_drain u_drain (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.bundle  (bundle),
		.free    (free),
		.m_valid (m_axis_tvalid),
		.m_ready (m_axis_tready),
		.m_res   (m_res)
	);

	assign m_axis_tdata = m_res.data;
	assign m_axis_tuser = m_res.dvalid;
	assign m_axis_tlast = m_res.last;

endmodule
`default_nettype wire
